/* sv/wfcc_pkg.sv */
// Shared types and constants for the woodwind fingering to DAC block.
`default_nettype none
package wfcc_pkg;

    localparam int NUM_FINGERS = 11;

    // Control change numbers
    localparam logic [6:0] CTRL_VOLUME       = 7'd7;
    localparam logic [6:0] CTRL_BREATH_HI    = 7'd30;
    localparam logic [6:0] CTRL_BREATH_LO    = 7'd31;
    localparam logic [6:0] CTRL_FINGER_FIRST = 7'd42;
    localparam logic [6:0] CTRL_FINGER_LAST  = 7'd63;
    localparam logic [6:0] CTRL_LED_KEY0     = 7'd43;
    localparam logic [6:0] CTRL_LED_KEY1     = 7'd45;
    localparam logic [6:0] CTRL_OCTAVE_DOWN  = 7'd70;
    localparam logic [6:0] CTRL_OCTAVE_UP    = 7'd72;

    // Octave settings in semitones
    localparam logic [4:0] OCTAVE_LOW  = 5'd0;
    localparam logic [4:0] OCTAVE_MID  = 5'd12;
    localparam logic [4:0] OCTAVE_HIGH = 5'd24;

    // LED bit positions
    localparam int LED_OCT_DOWN = 0;
    localparam int LED_OCT_UP   = 1;
    localparam int LED_KEY1     = 2;
    localparam int LED_KEY0     = 3;

    // Configuration register indexes
    localparam logic [1:0] REG_PITCH_OFFSET    = 2'd0;
    localparam logic [1:0] REG_TOUCH_THRESHOLD = 2'd1;
    localparam logic [1:0] REG_LED_THRESHOLD   = 2'd2;

    localparam logic [13:0] TOUCH_THRESHOLD_RESET = 14'd30;
    localparam logic [13:0] LED_THRESHOLD_RESET   = 14'd20;

    // DAC channels
    localparam logic [1:0] CHAN_PITCH  = 2'd0;
    localparam logic [1:0] CHAN_BREATH = 2'd1;

    // pitch*5478/10 = pitch*547 + floor(4*pitch/5); x/5 = (x*205)>>10 for x < 1024
    localparam logic [9:0] PITCH_STEP_INT = 10'd547;
    localparam logic [7:0] DIV5_RECIP     = 8'd205;

    typedef struct packed {
        logic [6:0]  pitch_offset;
        logic [13:0] touch_threshold;
        logic [13:0] led_threshold;
    } cfg_t;

    typedef struct packed {
        logic [NUM_FINGERS-1:0][6:0] finger_hi;
        logic [NUM_FINGERS-1:0][6:0] finger_lo;
        logic [6:0]                  breath_hi;
        logic [6:0]                  breath_lo;
        logic [4:0]                  octave;
        logic [6:0]                  volume;
        logic [3:0]                  led;
    } state_t;

    typedef struct packed {
        logic        dac_write;
        logic [1:0]  dac_channel;
        logic [15:0] dac_value;
        logic [3:0]  led_state;
        logic [6:0]  volume;
    } result_t;

endpackage
`default_nettype wire

/* sv/wfcc_if.sv */
// Valid/ready channel interfaces for control-change requests and DAC results.
`default_nettype none
interface wfcc_ctrl_if;
    logic       valid;
    logic       ready;
    logic [6:0] ctrl_number;
    logic [6:0] ctrl_value;

    modport source (output valid, output ctrl_number, output ctrl_value, input ready);
    modport sink   (input valid, input ctrl_number, input ctrl_value, output ready);
endinterface

interface wfcc_dac_if;
    logic        valid;
    logic        ready;
    logic        dac_write;
    logic [1:0]  dac_channel;
    logic [15:0] dac_value;
    logic [3:0]  led_state;
    logic [6:0]  volume;

    modport source (output valid, output dac_write, output dac_channel, output dac_value,
                    output led_state, output volume, input ready);
    modport sink   (input valid, input dac_write, input dac_channel, input dac_value,
                    input led_state, input volume, output ready);
endinterface
`default_nettype wire

/* sv/wfcc_regs.sv */
// Configuration registers and controller state (sensor halves, breath, octave, volume, LEDs).
`default_nettype none
module wfcc_regs (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cfg_we,
    input  wire logic [1:0]      cfg_index,
    input  wire logic [13:0]     cfg_data,
    input  wire logic            update,
    input  wire wfcc_pkg::state_t state_next,
    output wfcc_pkg::cfg_t       cfg,
    output wfcc_pkg::state_t     state
);

    wfcc_pkg::cfg_t   cfg_reg;
    wfcc_pkg::state_t state_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pitch_offset    <= 7'd0;
            cfg_reg.touch_threshold <= wfcc_pkg::TOUCH_THRESHOLD_RESET;
            cfg_reg.led_threshold   <= wfcc_pkg::LED_THRESHOLD_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                wfcc_pkg::REG_PITCH_OFFSET:    cfg_reg.pitch_offset    <= cfg_data[6:0];
                wfcc_pkg::REG_TOUCH_THRESHOLD: cfg_reg.touch_threshold <= cfg_data;
                wfcc_pkg::REG_LED_THRESHOLD:   cfg_reg.led_threshold   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Controller state, committed once per request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.finger_hi <= '0;
            state_reg.finger_lo <= '0;
            state_reg.breath_hi <= '0;
            state_reg.breath_lo <= '0;
            state_reg.octave    <= wfcc_pkg::OCTAVE_MID;
            state_reg.volume    <= '0;
            state_reg.led       <= '0;
        end
        else if (update)
        begin
            state_reg <= state_next;
        end
    end

    assign cfg   = cfg_reg;
    assign state = state_reg;

endmodule
`default_nettype wire

/* sv/wfcc_calc.sv */
// Per-request datapath: state update, fingering to pitch, DAC scaling, breath scaling, LEDs.
`default_nettype none
module wfcc_calc (
    input  wire logic             [6:0] ctrl_number,
    input  wire logic             [6:0] ctrl_value,
    input  wire wfcc_pkg::cfg_t         cfg,
    input  wire wfcc_pkg::state_t       state,
    output wfcc_pkg::state_t            state_next,
    output wfcc_pkg::result_t           result
);

    wfcc_pkg::state_t            nxt;
    logic [6:0]                  finger_rel;
    logic [3:0]                  finger_idx;
    logic [wfcc_pkg::NUM_FINGERS-1:0] f;
    logic [13:0]                 sensor0;
    logic [13:0]                 sensor1;
    logic [4:0]                  neg_sum;
    logic [1:0]                  pos_sum;
    logic signed [8:0]           pitch;
    logic [6:0]                  pitch_pos;
    logic [16:0]                 pitch_int;
    logic [16:0]                 frac_prod;
    logic [15:0]                 pitch_dac;
    logic [13:0]                 breath;
    logic [18:0]                 breath_prod;
    logic [15:0]                 breath_dac;
    logic                        is_finger;
    logic                        is_breath;
    logic                        is_octave;

    assign finger_rel = ctrl_number - wfcc_pkg::CTRL_FINGER_FIRST;
    assign finger_idx = finger_rel[4:1];
    assign is_finger  = ctrl_number inside {[wfcc_pkg::CTRL_FINGER_FIRST:
                                              wfcc_pkg::CTRL_FINGER_LAST]};
    assign is_breath  = ctrl_number inside {wfcc_pkg::CTRL_BREATH_HI, wfcc_pkg::CTRL_BREATH_LO};
    assign is_octave  = ctrl_number inside {wfcc_pkg::CTRL_OCTAVE_DOWN,
                                             wfcc_pkg::CTRL_OCTAVE_UP};

    // Register writes selected by control number
    always_comb
    begin
        nxt = state;
        if (is_finger)
        begin
            if (ctrl_number[0])
                nxt.finger_lo[finger_idx] = ctrl_value;
            else
                nxt.finger_hi[finger_idx] = ctrl_value;
        end
        case (ctrl_number)
            wfcc_pkg::CTRL_BREATH_HI: nxt.breath_hi = ctrl_value;
            wfcc_pkg::CTRL_BREATH_LO: nxt.breath_lo = ctrl_value;
            wfcc_pkg::CTRL_VOLUME:    nxt.volume    = ctrl_value;
            wfcc_pkg::CTRL_OCTAVE_DOWN:
            begin
                nxt.octave = (ctrl_value != 7'd0) ? wfcc_pkg::OCTAVE_LOW : wfcc_pkg::OCTAVE_MID;
                nxt.led[wfcc_pkg::LED_OCT_DOWN] = (ctrl_value != 7'd0);
            end
            wfcc_pkg::CTRL_OCTAVE_UP:
            begin
                nxt.octave = (ctrl_value != 7'd0) ? wfcc_pkg::OCTAVE_HIGH : wfcc_pkg::OCTAVE_MID;
                nxt.led[wfcc_pkg::LED_OCT_UP] = (ctrl_value != 7'd0);
            end
            wfcc_pkg::CTRL_LED_KEY0: nxt.led[wfcc_pkg::LED_KEY0] = (sensor0 > cfg.led_threshold);
            wfcc_pkg::CTRL_LED_KEY1: nxt.led[wfcc_pkg::LED_KEY1] = (sensor1 > cfg.led_threshold);
            default: ;
        endcase
    end

    // LED sensors read from the freshly written halves
    always_comb
    begin
        sensor0 = state.finger_hi[0] << 7 | 14'(state.finger_lo[0]);
        sensor1 = state.finger_hi[1] << 7 | 14'(state.finger_lo[1]);
        if (is_finger && finger_idx == 4'd0)
        begin
            sensor0 = ctrl_number[0] ? {state.finger_hi[0], ctrl_value}
                                     : {ctrl_value, state.finger_lo[0]};
        end
        if (is_finger && finger_idx == 4'd1)
        begin
            sensor1 = ctrl_number[0] ? {state.finger_hi[1], ctrl_value}
                                     : {ctrl_value, state.finger_lo[1]};
        end
    end

    // Closed keys
    always_comb
    begin
        for (int k = 0; k < wfcc_pkg::NUM_FINGERS; k++)
        begin
            f[k] = {nxt.finger_hi[k], nxt.finger_lo[k]} > cfg.touch_threshold;
        end
    end

    // Fingering rules; side key (finger 5) is ignored
    assign neg_sum = {3'd0, f[0], 1'b0} + 5'(f[1]) + 5'(f[1] & f[0]) + {3'd0, f[2], 1'b0}
                   + 5'(f[6]) + 5'(f[6] & f[1]) + 5'(f[7]) + 5'(f[8]) + 5'(f[8] & f[7])
                   + {3'd0, f[4], 1'b0} + {3'd0, f[10], 1'b0};
    assign pos_sum = 2'(f[3]) + 2'(f[9]);
    assign pitch   = 9'sd1 + $signed({{2{cfg.pitch_offset[6]}}, cfg.pitch_offset})
                   + $signed({4'd0, nxt.octave}) + $signed({7'd0, pos_sum})
                   - $signed({4'd0, neg_sum});

    // floor(pitch * 5478 / 10), zero for non-positive pitch
    assign pitch_pos = (pitch > 9'sd0) ? pitch[6:0] : 7'd0;
    assign pitch_int = 17'(pitch_pos) * 17'(wfcc_pkg::PITCH_STEP_INT);
    assign frac_prod = 17'({pitch_pos, 2'b00}) * 17'(wfcc_pkg::DIV5_RECIP);
    assign pitch_dac = pitch_int[15:0] + {9'd0, frac_prod[16:10]};

    // Breath times 20, saturated
    assign breath      = {nxt.breath_hi, nxt.breath_lo};
    assign breath_prod = ({5'd0, breath} << 4) + ({5'd0, breath} << 2);
    assign breath_dac  = (breath_prod[18:16] != 3'd0) ? 16'hFFFF : breath_prod[15:0];

    // Result
    always_comb
    begin
        result           = '0;
        result.led_state = nxt.led;
        result.volume    = nxt.volume;
        if (is_finger || is_octave)
        begin
            result.dac_write   = 1'b1;
            result.dac_channel = wfcc_pkg::CHAN_PITCH;
            result.dac_value   = pitch_dac;
        end
        else if (is_breath)
        begin
            result.dac_write   = 1'b1;
            result.dac_channel = wfcc_pkg::CHAN_BREATH;
            result.dac_value   = breath_dac;
        end
    end

    assign state_next = nxt;

endmodule
`default_nettype wire

/* sv/wind_fingering_cc_to_pitch_dac.sv */
// Top level: control-change requests in, DAC write results out.
//
// Each accepted control-change request yields exactly one result: it is first
// held in the request register, then the state update, fingering-to-pitch and
// DAC scaling logic settle into the result register.
// A new request is taken every cycle while results are drained; the request
// register keeps accepting while a finished result waits, and ready drops
// only once both the request and result registers are full. Configuration
// writes (pitch offset, touch and LED thresholds) take effect on the next
// clock and should be issued only while no request is in flight.
`default_nettype none
module wind_fingering_cc_to_pitch_dac (
    input  wire logic        clk,
    input  wire logic        rst_n,
    wfcc_ctrl_if.sink        ctrl,
    wfcc_dac_if.source       dac,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [13:0] cfg_data
);

    logic              req_valid_reg;
    logic [6:0]        req_number_reg;
    logic [6:0]        req_value_reg;
    logic              res_valid_reg;
    wfcc_pkg::result_t res_reg;
    wfcc_pkg::result_t res_next;
    wfcc_pkg::cfg_t    cfg;
    wfcc_pkg::state_t  state;
    wfcc_pkg::state_t  state_next;
    logic              advance;
    logic              ctrl_accept;

    // Request moves to the result register when that register is free or draining
    assign advance     = req_valid_reg && (!res_valid_reg || dac.ready);
    assign ctrl.ready  = !req_valid_reg || advance;
    assign ctrl_accept = ctrl.valid && ctrl.ready;

    // Request register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            req_valid_reg <= 1'b0;
        else if (ctrl.ready)
            req_valid_reg <= ctrl.valid;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl_accept)
        begin
            req_number_reg <= ctrl.ctrl_number;
            req_value_reg  <= ctrl.ctrl_value;
        end
    end

    wfcc_regs u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .update     (advance),
        .state_next (state_next),
        .cfg        (cfg),
        .state      (state)
    );

    wfcc_calc u_calc (
        .ctrl_number (req_number_reg),
        .ctrl_value  (req_value_reg),
        .cfg         (cfg),
        .state       (state),
        .state_next  (state_next),
        .result      (res_next)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (advance)
            res_valid_reg <= 1'b1;
        else if (dac.ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= res_next;
    end

    assign dac.valid       = res_valid_reg;
    assign dac.dac_write   = res_reg.dac_write;
    assign dac.dac_channel = res_reg.dac_channel;
    assign dac.dac_value   = res_reg.dac_value;
    assign dac.led_state   = res_reg.led_state;
    assign dac.volume      = res_reg.volume;

endmodule
`default_nettype wire
